// File: hdl/mcpg_pkg.sv
// ----------------------------------------------------------------------------
// mcpg_pkg
// Shared widths, request codes and the step job type of the midpoint circle
// point generator.
// ----------------------------------------------------------------------------
package mcpg_pkg;

  // Octant position width; decision carries four more bits
  localparam int unsigned RADIUS_BITS   = 10;
  localparam int unsigned DECISION_BITS = RADIUS_BITS + 4;
  localparam int unsigned CENTER_BITS   = 10;
  localparam int unsigned RADIUS_IN_BITS = 10;
  localparam int unsigned POINT_BITS    = 12;
  localparam int unsigned EXT_BITS      =
    (RADIUS_BITS > POINT_BITS) ? RADIUS_BITS : POINT_BITS;

  // Request kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // Job queue depth
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = 1;

  // Last point index of a group
  localparam logic [2:0] LAST_IDX = 3'd7;

  // One octant step handed from front to back
  typedef struct packed {
    logic [CENTER_BITS-1:0] cx;
    logic [CENTER_BITS-1:0] cy;
    logic [RADIUS_BITS-1:0] x;
    logic [RADIUS_BITS-1:0] y;
    logic                   finish;
  } mcpg_job_t;

  // Octant coordinate to point width (wraps or zero-extends)
  function automatic logic [POINT_BITS-1:0] to_point(input logic [RADIUS_BITS-1:0] v);
    logic [EXT_BITS-1:0] ext;
    ext = EXT_BITS'(v);
    return ext[POINT_BITS-1:0];
  endfunction

endpackage

// File: hdl/mcpg_if.sv
// ----------------------------------------------------------------------------
// mcpg_if
// Request and point channels of the midpoint circle point generator.
// ----------------------------------------------------------------------------
interface mcpg_req_if
  import mcpg_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [CENTER_BITS-1:0]    center_x;
  logic [CENTER_BITS-1:0]    center_y;
  logic [RADIUS_IN_BITS-1:0] radius;

  modport source (output valid, kind, center_x, center_y, radius, input ready);
  modport sink   (input valid, kind, center_x, center_y, radius, output ready);
endinterface

interface mcpg_pnt_if
  import mcpg_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic signed [POINT_BITS-1:0] point_x;
  logic signed [POINT_BITS-1:0] point_y;
  logic                         last_of_group;
  logic                         circle_done;

  modport source (output valid, point_x, point_y, last_of_group, circle_done,
                  input ready);
  modport sink   (input valid, point_x, point_y, last_of_group, circle_done,
                  output ready);
endinterface

// File: hdl/mcpg_front.sv
// ----------------------------------------------------------------------------
// mcpg_front
// Takes requests, holds the circle state and runs the midpoint update; each
// step that yields points is queued as a job.
// ----------------------------------------------------------------------------
module mcpg_front
  import mcpg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mcpg_req_if.sink    req_i,
  input  logic        q_full_i,
  output logic        push_o,
  output mcpg_job_t   job_o
);

  logic [CENTER_BITS-1:0]   cx_q, cy_q;
  logic [RADIUS_BITS-1:0]   x_q, y_q, x_d, y_d;
  logic [DECISION_BITS-1:0] dec_q, dec_d;
  logic                     active_q;
  logic                     accept, is_start, is_step;
  logic                     equal, past;
  logic [RADIUS_BITS-1:0]   r_eff;
  logic [DECISION_BITS-1:0] x_ext, y_ext;

  assign req_i.ready = !q_full_i;
  assign accept      = req_i.valid && req_i.ready;
  assign is_start    = accept && (req_i.kind == KIND_START);
  assign is_step     = accept && (req_i.kind == KIND_STEP) && active_q;
  assign r_eff       = RADIUS_BITS'(req_i.radius);

  assign equal = (x_q == y_q);
  assign past  = (x_q > y_q);
  assign x_ext = DECISION_BITS'(x_q);
  assign y_ext = DECISION_BITS'(y_q);

  // Midpoint rule
  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    dec_d = dec_q;
    if (!equal) begin
      if (dec_q[DECISION_BITS-1]) begin
        dec_d = dec_q + (x_ext << 2) + DECISION_BITS'(6);
      end else begin
        dec_d = dec_q + ((x_ext - y_ext) << 2) + DECISION_BITS'(10);
        y_d   = y_q - RADIUS_BITS'(1);
      end
      x_d = x_q + RADIUS_BITS'(1);
    end
  end

  // Job for the back end carries the pre-update position
  assign push_o     = is_step && !past;
  assign job_o.cx   = cx_q;
  assign job_o.cy   = cy_q;
  assign job_o.x    = x_q;
  assign job_o.y    = y_q;
  assign job_o.finish = equal || (x_d > y_d);

  // Circle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      dec_q    <= '0;
      active_q <= 1'b0;
    end else if (is_start) begin
      cx_q     <= req_i.center_x;
      cy_q     <= req_i.center_y;
      x_q      <= '0;
      y_q      <= r_eff;
      dec_q    <= DECISION_BITS'(3) - (DECISION_BITS'(r_eff) << 1);
      active_q <= 1'b1;
    end else if (is_step) begin
      if (past) begin
        active_q <= 1'b0;
      end else begin
        x_q   <= x_d;
        y_q   <= y_d;
        dec_q <= dec_d;
        if (job_o.finish) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  // A start always leaves a circle in progress
  a_start_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_start |=> active_q)
    else $error("start did not activate circle");

  // A finishing step ends the circle
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && job_o.finish && !is_start) |=> !active_q)
    else $error("circle still active after final step");

endmodule

// File: hdl/mcpg_fifo.sv
// ----------------------------------------------------------------------------
// mcpg_fifo
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module mcpg_fifo
  import mcpg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mcpg_job_t job_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output mcpg_job_t job_o
);

  mcpg_job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_q, rd_q;
  logic [QPTR_BITS:0]     cnt_q;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QPTR_BITS'(1);
      if (do_pop)  rd_q <= rd_q + QPTR_BITS'(1);
      cnt_q <= cnt_q + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
    end
  end

  // The front must never push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job queue overflow");

endmodule

// File: hdl/mcpg_back.sv
// ----------------------------------------------------------------------------
// mcpg_back
// Expands one queued job into its eight symmetric points, one per cycle while
// the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module mcpg_back
  import mcpg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  mcpg_job_t q_job_i,
  output logic      pop_o,
  mcpg_pnt_if.source pnt_o
);

  mcpg_job_t             job_q;
  logic                  busy_q;
  logic [2:0]            idx_q;
  logic                  out_valid_q;
  logic [POINT_BITS-1:0] px_q, py_q;
  logic                  last_q, done_q;
  logic                  load, last_pt;
  logic [RADIUS_BITS-1:0] a, b;
  logic [POINT_BITS-1:0]  ca, cb, ap, bp, px, py;

  assign load    = busy_q && (!out_valid_q || pnt_o.ready);
  assign last_pt = (idx_q == LAST_IDX);
  assign pop_o   = q_valid_i && (!busy_q || (load && last_pt));

  // Point select: bit 2 swaps x/y, bit 0 negates column, bit 1 negates row
  always_comb begin
    a  = idx_q[2] ? job_q.y : job_q.x;
    b  = idx_q[2] ? job_q.x : job_q.y;
    ca = POINT_BITS'(job_q.cx);
    cb = POINT_BITS'(job_q.cy);
    ap = to_point(a);
    bp = to_point(b);
    px = idx_q[0] ? (ca - ap) : (ca + ap);
    py = idx_q[1] ? (cb - bp) : (cb + bp);
  end

  // Job register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= q_job_i;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q   <= px;
      py_q   <= py;
      last_q <= last_pt;
      done_q <= last_pt && job_q.finish;
    end
  end

  // Sequencing control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (load) begin
        idx_q <= idx_q + 3'd1;
        if (last_pt) busy_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pnt_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign pnt_o.valid         = out_valid_q;
  assign pnt_o.point_x       = px_q;
  assign pnt_o.point_y       = py_q;
  assign pnt_o.last_of_group = last_q;
  assign pnt_o.circle_done   = done_q;

  // Circle end only ever marks the last point of a group
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> last_q)
    else $error("circle_done without last_of_group");

  // Point index holds while the output stage is stalled
  a_idx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !load && !pop_o) |=> $stable(idx_q))
    else $error("point index moved during stall");

endmodule

// File: hdl/midpoint_circle_point_generator.sv
// A step request is written into the job queue, popped into the back-end
// job register and leaves its first point in the output register; a start
// request gives no point. Throughput: one point per cycle while the receiver is
// ready, set by the back-end expander; the two-entry job queue absorbs bursts.
// Reset (rst_ni, asynchronous, active low) clears circle state, queue and
// output valid; no circle is in progress afterwards.
// ----------------------------------------------------------------------------
// midpoint_circle_point_generator
// Midpoint circle rasterizer: front end tracks the octant position, back end
// emits the eight symmetric points of each step.
// ----------------------------------------------------------------------------
module midpoint_circle_point_generator
  import mcpg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mcpg_req_if.sink   req_i,
  mcpg_pnt_if.source pnt_o
);

  logic      push, full, pop, q_valid;
  mcpg_job_t push_job, pop_job;

  mcpg_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .q_full_i (full),
    .push_o   (push),
    .job_o    (push_job)
  );

  mcpg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (pop_job)
  );

  mcpg_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_job_i   (pop_job),
    .pop_o     (pop),
    .pnt_o     (pnt_o)
  );

endmodule

// File: tb/mcpg_point_checker.sv
// ----------------------------------------------------------------------------
// mcpg_point_checker
// Watches the request and point channels of the circle point generator,
// traces each circle in its own octant model and compares every point that
// leaves the block against the oldest point still owed.
// ----------------------------------------------------------------------------
module mcpg_point_checker
  import mcpg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mcpg_req_if        req_i,
  mcpg_pnt_if        pnt_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [POINT_BITS-1:0] px;
    logic [POINT_BITS-1:0] py;
    logic                  last;
    logic                  done;
  } circle_point_t;

  // Traced circle state
  logic [CENTER_BITS-1:0]          trace_cx;
  logic [CENTER_BITS-1:0]          trace_cy;
  logic [RADIUS_BITS-1:0]          trace_x;
  logic [RADIUS_BITS-1:0]          trace_y;
  logic signed [DECISION_BITS-1:0] trace_dec;
  logic                            trace_active;

  circle_point_t owed_points[$];
  circle_point_t owed;

  initial fail_count_o = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] point mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  function automatic void owe_point(input int px, input int py,
                                    input logic last, input logic done);
    circle_point_t p;
    p.px   = POINT_BITS'(px);
    p.py   = POINT_BITS'(py);
    p.last = last;
    p.done = done;
    owed_points.push_back(p);
  endfunction

  // One accepted request: latch a new circle or emit one octant step
  function automatic void trace_request(input logic kind,
                                        input logic [CENTER_BITS-1:0] cx_in,
                                        input logic [CENTER_BITS-1:0] cy_in,
                                        input logic [RADIUS_IN_BITS-1:0] r_in);
    int   x;
    int   y;
    int   cx;
    int   cy;
    logic finish;
    if (kind == KIND_START) begin
      trace_cx     = cx_in;
      trace_cy     = cy_in;
      trace_x      = '0;
      trace_y      = RADIUS_BITS'(r_in);
      trace_dec    = DECISION_BITS'(3 - 2 * int'(trace_y));
      trace_active = 1'b1;
      return;
    end
    if (!trace_active) return;
    x  = int'(trace_x);
    y  = int'(trace_y);
    cx = int'(trace_cx);
    cy = int'(trace_cy);
    // x already past y: the circle closes silently
    if (x > y) begin
      trace_active = 1'b0;
      return;
    end
    if (x == y) begin
      finish = 1'b1;
    end else begin
      if (trace_dec < 0) begin
        trace_dec = DECISION_BITS'(int'(trace_dec) + 4 * x + 6);
      end else begin
        trace_dec = DECISION_BITS'(int'(trace_dec) + 4 * (x - y) + 10);
        trace_y   = trace_y - 1'b1;
      end
      trace_x = trace_x + 1'b1;
      finish  = trace_x > trace_y;
    end
    // Eight-way symmetry, fixed order
    owe_point(cx + x, cy + y, 1'b0, 1'b0);
    owe_point(cx - x, cy + y, 1'b0, 1'b0);
    owe_point(cx + x, cy - y, 1'b0, 1'b0);
    owe_point(cx - x, cy - y, 1'b0, 1'b0);
    owe_point(cx + y, cy + x, 1'b0, 1'b0);
    owe_point(cx - y, cy + x, 1'b0, 1'b0);
    owe_point(cx + y, cy - x, 1'b0, 1'b0);
    owe_point(cx - y, cy - x, 1'b1, finish);
    if (finish) trace_active = 1'b0;
  endfunction

  // Compare outgoing points, then trace incoming requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trace_cx     = '0;
      trace_cy     = '0;
      trace_x      = '0;
      trace_y      = '0;
      trace_dec    = '0;
      trace_active = 1'b0;
      owed_points.delete();
    end else begin
      if (pnt_i.valid && pnt_i.ready) begin
        if (owed_points.size() == 0) begin
          report_mismatch($sformatf("unexpected point (%0d,%0d) last=%b done=%b",
                                    pnt_i.point_x, pnt_i.point_y,
                                    pnt_i.last_of_group, pnt_i.circle_done));
        end else begin
          owed = owed_points.pop_front();
          if (pnt_i.point_x !== owed.px || pnt_i.point_y !== owed.py ||
              pnt_i.last_of_group !== owed.last || pnt_i.circle_done !== owed.done) begin
            report_mismatch($sformatf("got (%h,%h) last=%b done=%b, want (%h,%h) last=%b done=%b",
                                      pnt_i.point_x, pnt_i.point_y, pnt_i.last_of_group,
                                      pnt_i.circle_done, owed.px, owed.py, owed.last,
                                      owed.done));
          end
        end
      end
      if (req_i.valid && req_i.ready)
        trace_request(req_i.kind, req_i.center_x, req_i.center_y, req_i.radius);
    end
    pending_o = owed_points.size();
  end

endmodule

// File: tb/tb_midpoint_circle_point_generator.sv
// ----------------------------------------------------------------------------
// tb_midpoint_circle_point_generator
// Drives start and step requests into the circle point generator: a directed
// set of corner circles, then random circles run to completion, cut short or
// overstepped, under three sender/receiver stall mixes. The checker beside
// the block owns prediction; this top reports the verdict.
// ----------------------------------------------------------------------------
module tb_midpoint_circle_point_generator;
  import mcpg_pkg::*;

  localparam int RANDOM_REQUESTS = 360;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  int   random_sent;

  mcpg_req_if req_if ();
  mcpg_pnt_if pnt_if ();

  midpoint_circle_point_generator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .pnt_o  (pnt_if)
  );

  mcpg_point_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .pnt_i        (pnt_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver stalls
  always @(negedge clk_i) begin
    pnt_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // Send one request; entered and left at a falling edge, valid kept high
  task automatic send_request(input logic kind, input logic [CENTER_BITS-1:0] cx,
                              input logic [CENTER_BITS-1:0] cy,
                              input logic [RADIUS_IN_BITS-1:0] r);
    if ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < snd_idle_pct) @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.kind     <= kind;
    req_if.center_x <= cx;
    req_if.center_y <= cy;
    req_if.radius   <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Step requests carry random don't-care fields
  task automatic send_step();
    send_request(KIND_STEP, CENTER_BITS'($urandom), CENTER_BITS'($urandom),
                 RADIUS_IN_BITS'($urandom));
  endtask

  task automatic run_circle(input int cx, input int cy, input int r, input int steps);
    send_request(KIND_START, CENTER_BITS'(cx), CENTER_BITS'(cy), RADIUS_IN_BITS'(r));
    repeat (steps) send_step();
  endtask

  // Stall mix by progress through the random part
  task automatic pick_stall_mix();
    case ((random_sent * 3) / RANDOM_REQUESTS)
      0: begin
        snd_idle_pct = 16;
        rcv_idle_pct = 55;
      end
      1: begin
        snd_idle_pct = 55;
        rcv_idle_pct = 16;
      end
      default: begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
    endcase
  endtask

  initial begin
    int r;
    int need;
    int steps;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.kind     = KIND_START;
    req_if.center_x = '0;
    req_if.center_y = '0;
    req_if.radius   = '0;
    pnt_if.ready    = 1'b0;
    random_sent     = 0;
    pick_stall_mix();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: step with no circle, zero radius, extreme centers and radii,
    // restart while a circle runs, steps after a circle has closed
    send_request(KIND_STEP, '1, '1, '1);
    run_circle(0, 0, 0, 2);
    run_circle(1023, 1023, 1023, 3);
    run_circle(0, 1023, 1, 2);
    run_circle(512, 5, 2, 2);
    run_circle(3, 1020, 7, 6);

    // Random circles: mostly full runs, some cut short, some overstepped
    while (random_sent < RANDOM_REQUESTS) begin
      pick_stall_mix();
      r    = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(40);
      need = (r * 181) / 256 + 2;
      case ($urandom_range(9))
        0:       steps = $urandom_range(need);
        1:       steps = need + $urandom_range(1, 3);
        default: steps = need;
      endcase
      if (r > 40 && steps > 12) steps = $urandom_range(1, 12);
      if ($urandom_range(19) == 0) begin
        send_step();
        random_sent++;
      end
      run_circle($urandom_range(1023), $urandom_range(1023), r, steps);
      random_sent += steps + 1;
    end
    req_if.valid <= 1'b0;

    // Drain
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
